// ===== hw/rtl/grid_astar_path_search_macros.svh =====
// Assertion macros shared by the grid A* search RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define GASP_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("gasp assertion failed");
// condition must never be seen outside reset
`define GASP_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("gasp forbidden condition seen");
`else
`define GASP_ASSERT(lbl, ck, rn, prop)
`define GASP_NEVER(lbl, ck, rn, cond)
`endif

`endif

// ===== hw/rtl/gasp_pkg.sv =====
// Types and constants for the grid A* search block.
// No dependencies; imported by gasp_isqrt and grid_astar_path_search.
package gasp_pkg;

  localparam int COORD_W  = 5;
  localparam int CELL_W   = 2 * COORD_W;
  localparam int CELLS    = 1 << CELL_W;
  localparam int CNT_W    = CELL_W + 1;
  localparam int COST_W   = 11;
  localparam int H_FRAC   = 8;
  localparam int H_W      = 14;
  localparam int SQ_W     = 11;
  localparam int F_W      = COST_W + H_FRAC + 1;
  localparam int PAR_W    = 3;
  localparam int KIND_W   = 2;
  localparam int DIM_W    = 6;
  localparam int ITER_W   = 10;
  localparam int PIDX_W   = 10;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // grid extent, fixed by the 5 bit coordinates
  localparam logic [DIM_W-1:0] GRID_MAX = DIM_W'(1 << COORD_W);
  localparam logic [COORD_W-1:0] COORD_LAST = {COORD_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOCK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_SEARCH = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_WRITE   = 3'd0;
  localparam logic [STAT_W-1:0] ST_GOAL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_LIMIT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 3'd4;
  localparam logic [STAT_W-1:0] ST_ENTRY   = 3'd5;
  localparam logic [STAT_W-1:0] ST_BEYOND  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER   = 2'd2;

  // parent codes: direction back towards the parent cell
  localparam logic [PAR_W-1:0] PAR_NONE = 3'd0;
  localparam logic [PAR_W-1:0] PAR_XM   = 3'd1;
  localparam logic [PAR_W-1:0] PAR_YM   = 3'd2;
  localparam logic [PAR_W-1:0] PAR_YP   = 3'd3;
  localparam logic [PAR_W-1:0] PAR_XP   = 3'd4;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [H_W-1:0]    h;
    logic [PAR_W-1:0]  par;
    logic              closed;
    logic              opened;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

// ===== hw/rtl/gasp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies; instanced for every store of the search block.
module gasp_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gasp_isqrt.sv =====
// Bit-serial integer square root for the fixed point heuristic.
// Depends on gasp_pkg; one result bit per cycle.
module gasp_isqrt import gasp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] sq,
  output logic            done,
  output logic [H_W-1:0]  root
);

  localparam int VAL_W = 2 * H_W;
  localparam int REM_W = H_W + 3;
  localparam int CW    = $clog2(H_W);

  logic [VAL_W-1:0] val_r, val_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [H_W-1:0]   root_r, root_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] remt;
  logic [REM_W-1:0] trial;

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    remt     = {rem_r[REM_W-3:0], val_r[VAL_W-1:VAL_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      // radicand is sq scaled by 2^(2*H_FRAC)
      val_nxt  = VAL_W'({sq, {(2 * H_FRAC){1'b0}}});
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      val_nxt = {val_r[VAL_W-3:0], 2'b00};
      if (remt >= trial) begin
        rem_nxt  = remt - trial;
        root_nxt = {root_r[H_W-2:0], 1'b1};
      end else begin
        rem_nxt  = remt;
        root_nxt = {root_r[H_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(H_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/grid_astar_path_search.sv =====
// Top level of the grid A* path search block: sequencer and stores.
// Depends on gasp_pkg, gasp_ram, gasp_isqrt and the assertion macro header.
//
// One item at a time: raise start while busy is low and the item is taken
// at that edge. busy falls as the single result is shown, so the next item
// may be taken at the edge that ends the result cycle. Each result sits on
// the out_ ports for exactly one cycle with out_valid high and cannot be
// held off. A cell write or unknown func shows its result in the cycle
// right after the accepting edge, as does a path read past the stored
// path; a path read inside it first reads the path store in S_RD_PATH.
// A search first checks the goal, then clears the per-cell store (one
// cell a cycle), then per expansion scans the open list (open-list RAM
// read feeding the node RAM read), closes the gap in the list, closes
// the node, and per neighbour reads the kind and node stores and, when the
// neighbour improves, runs the bit-serial square root of the heuristic;
// the path is then rebuilt from the goal, a write and a parent step per
// cell. After reset the cell-kind store is swept to open, with busy high;
// configuration writes are taken at any time and must only be made while
// the block is idle.
`include "grid_astar_path_search_macros.svh"

module grid_astar_path_search import gasp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // item channel
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [COORD_W-1:0]   in_cell_x,
  input  logic [COORD_W-1:0]   in_cell_y,
  input  logic [KIND_W-1:0]    in_cell_kind,
  input  logic [COORD_W-1:0]   in_goal_x,
  input  logic [COORD_W-1:0]   in_goal_y,
  input  logic [PIDX_W-1:0]    in_path_index,
  // result channel
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic [CNT_W-1:0]     out_path_length,
  output logic [CNT_W-1:0]     out_expansions,
  output logic [COORD_W-1:0]   out_entry_x,
  output logic [COORD_W-1:0]   out_entry_y,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [14:0] {
    S_CLR_KIND = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_RD_PATH  = 15'b000000000000100,
    S_GOAL_CHK = 15'b000000000001000,
    S_CLR_NODE = 15'b000000000010000,
    S_SEED     = 15'b000000000100000,
    S_TOP      = 15'b000000001000000,
    S_SCAN     = 15'b000000010000000,
    S_SHIFT    = 15'b000000100000000,
    S_CLOSE    = 15'b000001000000000,
    S_NB_ISSUE = 15'b000010000000000,
    S_NB_EVAL  = 15'b000100000000000,
    S_SQRT     = 15'b001000000000000,
    S_PATH_WR  = 15'b010000000000000,
    S_PATH_PAR = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [DIM_W-1:0]  gw_r, gh_r;
  logic [ITER_W-1:0] maxit_r;
  logic [DIM_W-1:0]  gw_eff, gh_eff;

  // item fields held for the search
  logic [COORD_W-1:0] sx_r, sy_r, gx_r, gy_r;
  logic [COORD_W-1:0] sx_nxt, sy_nxt, gx_nxt, gy_nxt;

  // search bookkeeping
  logic [CELL_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  open_cnt_r, open_cnt_nxt;
  logic [CNT_W-1:0]  iter_r, iter_nxt;
  logic [CNT_W-1:0]  path_cnt_r, path_cnt_nxt;
  logic [CNT_W-1:0]  last_exp_r, last_exp_nxt;
  logic [STAT_W-1:0] srch_stat_r, srch_stat_nxt;

  // open-list scan pipeline
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              v1_r, v1_nxt, v2_r, v2_nxt;
  logic [CELL_W-1:0] idx1_r, idx1_nxt, idx2_r, idx2_nxt;
  logic [CELL_W-1:0] cell2_r, cell2_nxt;
  logic [CELL_W-1:0] best_i_r, best_i_nxt;
  logic [CELL_W-1:0] best_cell_r, best_cell_nxt;
  node_t             best_node_r, best_node_nxt;
  logic [F_W-1:0]    bf_r, bf_nxt;
  logic [H_W-1:0]    bh_r, bh_nxt;
  logic [F_W-1:0]    f_cand;

  // list compaction
  logic [CNT_W-1:0]  sh_rd_r, sh_rd_nxt;
  logic [CELL_W-1:0] sh_w_r, sh_w_nxt;
  logic              sh_v_r, sh_v_nxt;

  // neighbour handling
  logic [1:0]         k_r, k_nxt;
  logic [COORD_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [COST_W:0]    nd_r, nd_nxt;
  logic               nb_open_r, nb_open_nxt;
  logic [COORD_W-1:0] cx, cy;
  logic               nb_ok;
  logic [COORD_W-1:0] nb_x, nb_y;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    sq;
  logic               sq_start;
  logic               sq_done;
  logic [H_W-1:0]     sq_root;
  logic [COST_W:0]    nd_val;

  // path rebuild
  logic [CELL_W-1:0] pcur_r, pcur_nxt;
  logic [COORD_W-1:0] px, py;
  logic               pmove;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [COORD_W-1:0] out_ex_r, out_ex_nxt, out_ey_r, out_ey_nxt;

  // RAM ports
  logic              k_we, n_we, o_we, p_we;
  logic [CELL_W-1:0] k_waddr, k_raddr, n_waddr, n_raddr;
  logic [CELL_W-1:0] o_waddr, o_raddr, p_waddr, p_raddr;
  logic [KIND_W-1:0] k_wdata, k_rdata;
  node_t             n_wdata, n_rdata;
  logic [CELL_W-1:0] o_wdata, o_rdata, p_wdata, p_rdata;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // grid register 0 acts as 1, anything above the store as the store size
  assign gw_eff = (gw_r == '0) ? DIM_W'(1) : ((gw_r > GRID_MAX) ? GRID_MAX : gw_r);
  assign gh_eff = (gh_r == '0) ? DIM_W'(1) : ((gh_r > GRID_MAX) ? GRID_MAX : gh_r);

  assign cx = best_cell_r[COORD_W-1:0];
  assign cy = best_cell_r[CELL_W-1:COORD_W];

  // neighbour order: x-1, y-1, y+1, x+1
  always_comb begin
    nb_x  = cx;
    nb_y  = cy;
    nb_ok = 1'b0;
    case (k_r)
      2'd0: begin
        nb_x  = cx - 1'b1;
        nb_ok = (cx != '0);
      end
      2'd1: begin
        nb_y  = cy - 1'b1;
        nb_ok = (cy != '0);
      end
      2'd2: begin
        nb_y  = cy + 1'b1;
        nb_ok = (({1'b0, cy} + 1'b1) < gh_eff);
      end
      2'd3: begin
        nb_x  = cx + 1'b1;
        nb_ok = (({1'b0, cx} + 1'b1) < gw_eff);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign dx = (nx_r > gx_r) ? (nx_r - gx_r) : (gx_r - nx_r);
  assign dy = (ny_r > gy_r) ? (ny_r - gy_r) : (gy_r - ny_r);
  assign sq = (SQ_W'(dx) * SQ_W'(dx)) + (SQ_W'(dy) * SQ_W'(dy));
  assign nd_val = {1'b0, best_node_r.cost} + 1'b1;

  assign f_cand = F_W'({n_rdata.cost, {H_FRAC{1'b0}}}) + F_W'(n_rdata.h);

  // step back along the parent link
  always_comb begin
    px    = pcur_r[COORD_W-1:0];
    py    = pcur_r[CELL_W-1:COORD_W];
    pmove = 1'b0;
    case (n_rdata.par)
      PAR_XM: begin
        px    = px - 1'b1;
        pmove = (pcur_r[COORD_W-1:0] != '0);
      end
      PAR_YM: begin
        py    = py - 1'b1;
        pmove = (pcur_r[CELL_W-1:COORD_W] != '0);
      end
      PAR_YP: begin
        py    = py + 1'b1;
        pmove = (pcur_r[CELL_W-1:COORD_W] != COORD_LAST);
      end
      PAR_XP: begin
        px    = px + 1'b1;
        pmove = (pcur_r[COORD_W-1:0] != COORD_LAST);
      end
      default: pmove = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    clr_nxt       = clr_r;
    open_cnt_nxt  = open_cnt_r;
    iter_nxt      = iter_r;
    path_cnt_nxt  = path_cnt_r;
    last_exp_nxt  = last_exp_r;
    srch_stat_nxt = srch_stat_r;
    iss_nxt       = iss_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    idx1_nxt      = idx1_r;
    idx2_nxt      = idx2_r;
    cell2_nxt     = cell2_r;
    best_i_nxt    = best_i_r;
    best_cell_nxt = best_cell_r;
    best_node_nxt = best_node_r;
    bf_nxt        = bf_r;
    bh_nxt        = bh_r;
    sh_rd_nxt     = sh_rd_r;
    sh_w_nxt      = sh_w_r;
    sh_v_nxt      = 1'b0;
    k_nxt         = k_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    nd_nxt        = nd_r;
    nb_open_nxt   = nb_open_r;
    pcur_nxt      = pcur_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_ex_nxt     = out_ex_r;
    out_ey_nxt     = out_ey_r;
    sq_start = 1'b0;
    k_we = 1'b0; k_waddr = '0; k_wdata = KIND_OPEN; k_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0;        n_raddr = '0;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0;        o_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0;        p_raddr = '0;

    case (state_r)
      S_CLR_KIND: begin
        k_we    = 1'b1;
        k_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          out_ex_nxt = '0;
          out_ey_nxt = '0;
          case (in_func)
            FN_WRITE: begin
              k_we    = 1'b1;
              k_waddr = {in_cell_y, in_cell_x};
              k_wdata = (in_cell_kind == KIND_BAD) ? KIND_OPEN : in_cell_kind;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_WRITE;
            end
            FN_SEARCH: begin
              sx_nxt    = in_cell_x;
              sy_nxt    = in_cell_y;
              gx_nxt    = in_goal_x;
              gy_nxt    = in_goal_y;
              k_raddr   = {in_goal_y, in_goal_x};
              state_nxt = S_GOAL_CHK;
            end
            FN_READ: begin
              if (CNT_W'(in_path_index) < path_cnt_r) begin
                // path is stored goal first, so index from the far end
                p_raddr   = CELL_W'(path_cnt_r - CNT_W'(in_path_index) - 1'b1);
                state_nxt = S_RD_PATH;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BEYOND;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_WRITE;
            end
          endcase
        end
      end

      S_RD_PATH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_ENTRY;
        out_ex_nxt     = p_rdata[COORD_W-1:0];
        out_ey_nxt     = p_rdata[CELL_W-1:COORD_W];
        state_nxt      = S_IDLE;
      end

      S_GOAL_CHK: begin
        if (({1'b0, gx_r} >= gw_eff) || ({1'b0, gy_r} >= gh_eff) ||
            (k_rdata == KIND_WALL) || (k_rdata == KIND_LOCK)) begin
          path_cnt_nxt   = '0;
          last_exp_nxt   = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BLOCKED;
          state_nxt      = S_IDLE;
        end else begin
          clr_nxt   = '0;
          state_nxt = S_CLR_NODE;
        end
      end

      S_CLR_NODE: begin
        n_we    = 1'b1;
        n_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_SEED;
        end
      end

      S_SEED: begin
        iter_nxt     = '0;
        open_cnt_nxt = '0;
        if (({1'b0, sx_r} < gw_eff) && ({1'b0, sy_r} < gh_eff)) begin
          o_we    = 1'b1;
          o_waddr = '0;
          o_wdata = {sy_r, sx_r};
          n_we    = 1'b1;
          n_waddr = {sy_r, sx_r};
          n_wdata.opened = 1'b1;
          open_cnt_nxt = CNT_W'(1);
        end
        state_nxt = S_TOP;
      end

      S_TOP: begin
        if (iter_r > CNT_W'(maxit_r)) begin
          srch_stat_nxt = ST_LIMIT;
          last_exp_nxt  = iter_r;
          path_cnt_nxt  = '0;
          pcur_nxt      = {gy_r, gx_r};
          state_nxt     = S_PATH_WR;
        end else if (open_cnt_r == '0) begin
          srch_stat_nxt = ST_EMPTY;
          last_exp_nxt  = iter_r;
          path_cnt_nxt  = '0;
          pcur_nxt      = {gy_r, gx_r};
          state_nxt     = S_PATH_WR;
        end else begin
          iss_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      // list read -> node read -> compare, one entry per cycle
      S_SCAN: begin
        if (iss_r < open_cnt_r) begin
          o_raddr  = iss_r[CELL_W-1:0];
          v1_nxt   = 1'b1;
          idx1_nxt = iss_r[CELL_W-1:0];
          iss_nxt  = iss_r + 1'b1;
        end
        if (v1_r) begin
          n_raddr   = o_rdata;
          v2_nxt    = 1'b1;
          idx2_nxt  = idx1_r;
          cell2_nxt = o_rdata;
        end
        if (v2_r) begin
          // first entry wins ties on both f and h
          if ((idx2_r == '0) || (f_cand < bf_r) ||
              ((f_cand == bf_r) && (n_rdata.h < bh_r))) begin
            best_i_nxt    = idx2_r;
            best_cell_nxt = cell2_r;
            best_node_nxt = n_rdata;
            bf_nxt        = f_cand;
            bh_nxt        = n_rdata.h;
          end
        end
        if (!(iss_r < open_cnt_r) && !v1_r && !v2_r) begin
          sh_rd_nxt = CNT_W'(best_i_r) + 1'b1;
          state_nxt = S_SHIFT;
        end
      end

      // close the gap left by the taken entry
      S_SHIFT: begin
        if (sh_v_r) begin
          o_we    = 1'b1;
          o_waddr = sh_w_r;
          o_wdata = o_rdata;
        end
        if (sh_rd_r < open_cnt_r) begin
          o_raddr   = sh_rd_r[CELL_W-1:0];
          sh_v_nxt  = 1'b1;
          sh_w_nxt  = CELL_W'(sh_rd_r - 1'b1);
          sh_rd_nxt = sh_rd_r + 1'b1;
        end else if (!sh_v_r) begin
          open_cnt_nxt = open_cnt_r - 1'b1;
          state_nxt    = S_CLOSE;
        end
      end

      S_CLOSE: begin
        n_we    = 1'b1;
        n_waddr = best_cell_r;
        n_wdata = best_node_r;
        n_wdata.opened = 1'b0;
        n_wdata.closed = 1'b1;
        if (best_cell_r == {gy_r, gx_r}) begin
          srch_stat_nxt = ST_GOAL;
          last_exp_nxt  = iter_r;
          path_cnt_nxt  = '0;
          pcur_nxt      = {gy_r, gx_r};
          state_nxt     = S_PATH_WR;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_NB_ISSUE;
        end
      end

      S_NB_ISSUE: begin
        if (nb_ok) begin
          k_raddr   = {nb_y, nb_x};
          n_raddr   = {nb_y, nb_x};
          nx_nxt    = nb_x;
          ny_nxt    = nb_y;
          state_nxt = S_NB_EVAL;
        end else if (k_r == 2'd3) begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = S_TOP;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_NB_EVAL: begin
        if ((k_rdata != KIND_WALL) && !n_rdata.closed &&
            ((nd_val < {1'b0, n_rdata.cost}) || !n_rdata.opened)) begin
          nd_nxt      = nd_val;
          nb_open_nxt = n_rdata.opened;
          sq_start    = 1'b1;
          state_nxt   = S_SQRT;
        end else if (k_r == 2'd3) begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = S_TOP;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_NB_ISSUE;
        end
      end

      S_SQRT: begin
        if (sq_done) begin
          n_we    = 1'b1;
          n_waddr = {ny_r, nx_r};
          n_wdata.cost   = nd_r[COST_W-1:0];
          n_wdata.h      = sq_root;
          n_wdata.par    = PAR_XP - PAR_W'(k_r);
          n_wdata.closed = 1'b0;
          n_wdata.opened = 1'b1;
          if (!nb_open_r && (open_cnt_r < CNT_W'(CELLS))) begin
            o_we         = 1'b1;
            o_waddr      = open_cnt_r[CELL_W-1:0];
            o_wdata      = {ny_r, nx_r};
            open_cnt_nxt = open_cnt_r + 1'b1;
          end
          if (k_r == 2'd3) begin
            iter_nxt  = iter_r + 1'b1;
            state_nxt = S_TOP;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_NB_ISSUE;
          end
        end
      end

      // path is written goal first; reads index it from the far end
      S_PATH_WR: begin
        p_we         = 1'b1;
        p_waddr      = path_cnt_r[CELL_W-1:0];
        p_wdata      = pcur_r;
        path_cnt_nxt = path_cnt_r + 1'b1;
        n_raddr      = pcur_r;
        state_nxt    = S_PATH_PAR;
      end

      S_PATH_PAR: begin
        if (pmove && (path_cnt_r < CNT_W'(CELLS))) begin
          pcur_nxt  = {py, px};
          state_nxt = S_PATH_WR;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = srch_stat_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR_KIND;
      clr_r       <= '0;
      gw_r        <= DIM_W'(32);
      gh_r        <= DIM_W'(32);
      maxit_r     <= ITER_W'(100);
      open_cnt_r  <= '0;
      iter_r      <= '0;
      path_cnt_r  <= '0;
      last_exp_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sh_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      open_cnt_r  <= open_cnt_nxt;
      iter_r      <= iter_nxt;
      path_cnt_r  <= path_cnt_nxt;
      last_exp_r  <= last_exp_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      sh_v_r      <= sh_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  gw_r    <= cfg_data[DIM_W-1:0];
          CFG_HEIGHT: gh_r    <= cfg_data[DIM_W-1:0];
          CFG_ITER:   maxit_r <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
    end
    sx_r         <= sx_nxt;
    sy_r         <= sy_nxt;
    gx_r         <= gx_nxt;
    gy_r         <= gy_nxt;
    srch_stat_r  <= srch_stat_nxt;
    iss_r        <= iss_nxt;
    idx1_r       <= idx1_nxt;
    idx2_r       <= idx2_nxt;
    cell2_r      <= cell2_nxt;
    best_i_r     <= best_i_nxt;
    best_cell_r  <= best_cell_nxt;
    best_node_r  <= best_node_nxt;
    bf_r         <= bf_nxt;
    bh_r         <= bh_nxt;
    sh_rd_r      <= sh_rd_nxt;
    sh_w_r       <= sh_w_nxt;
    k_r          <= k_nxt;
    nx_r         <= nx_nxt;
    ny_r         <= ny_nxt;
    nd_r         <= nd_nxt;
    nb_open_r    <= nb_open_nxt;
    pcur_r       <= pcur_nxt;
    out_status_r <= out_status_nxt;
    out_ex_r     <= out_ex_nxt;
    out_ey_r     <= out_ey_nxt;
  end

  gasp_ram #(.W(KIND_W), .D(CELLS)) u_kind_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  gasp_ram #(.W(NODE_W), .D(CELLS)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  gasp_ram #(.W(CELL_W), .D(CELLS)) u_open_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  gasp_ram #(.W(CELL_W), .D(CELLS)) u_path_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  gasp_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .sq(sq),
    .done(sq_done), .root(sq_root)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_path_length = path_cnt_r;
  assign out_expansions  = last_exp_r;
  assign out_entry_x     = out_ex_r;
  assign out_entry_y     = out_ey_r;

  // a result is only ever shown with the sequencer back at rest
  `GASP_ASSERT(a_out_idle, clk, rst_n, out_valid_r |-> (state_r == S_IDLE))
  // the scan never runs on an empty list
  `GASP_NEVER(a_scan_empty, clk, rst_n, (state_r == S_SCAN) && (open_cnt_r == '0))
  // an expansion never starts past the iteration limit
  `GASP_ASSERT(a_iter_cap, clk, rst_n, (state_r == S_SCAN) |-> (iter_r <= CNT_W'(maxit_r)))
  // a path entry result always comes straight from the path store read
  `GASP_ASSERT(a_entry_src, clk, rst_n,
    (out_valid_r && (out_status_r == ST_ENTRY)) |-> ($past(state_r) == S_RD_PATH))

endmodule

// ===== dv/grid_astar_path_search_test.sv =====
// Self-checking testbench for grid_astar_path_search: directed and random items,
// each checked against an in-bench A* predictor. Depends on gasp_pkg and the RTL.
`timescale 1ns / 1ps

module grid_astar_path_search_test;
  import gasp_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   path_length;
    logic [CNT_W-1:0]   expansions;
    logic [COORD_W-1:0] entry_x;
    logic [COORD_W-1:0] entry_y;
  } search_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_func = FN_WRITE;
  logic [COORD_W-1:0]   in_cell_x = '0;
  logic [COORD_W-1:0]   in_cell_y = '0;
  logic [KIND_W-1:0]    in_cell_kind = KIND_OPEN;
  logic [COORD_W-1:0]   in_goal_x = '0;
  logic [COORD_W-1:0]   in_goal_y = '0;
  logic [PIDX_W-1:0]    in_path_index = '0;
  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [CNT_W-1:0]     out_path_length;
  logic [CNT_W-1:0]     out_expansions;
  logic [COORD_W-1:0]   out_entry_x;
  logic [COORD_W-1:0]   out_entry_y;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  grid_astar_path_search DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: grid, per-cell search marks, stored route
  logic [KIND_W-1:0] kind_store [CELLS];
  int                g_cost [CELLS];
  longint unsigned   h_dist [CELLS];
  int                back_dir [CELLS];
  bit                is_closed [CELLS];
  bit                is_open [CELLS];
  int                open_q [CELLS];
  int                open_n;
  int                route [CELLS];
  int                route_len;
  int                last_iter;
  int                width_reg = 32, height_reg = 32, iter_reg = 100;
  int                step_dx [4] = '{-1, 0, 0, 1};
  int                step_dy [4] = '{0, -1, 1, 0};

  search_result_t pending_results [$];
  int  mismatches, results_seen, items_sent, searches_run;
  bit  no_gaps;

  function automatic int clamp_dim(input int v);
    if (v == 0) return 1;
    return (v > 32) ? 32 : v;
  endfunction

  // exact floor square root by bit-wise trial
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned euclid_h(input int x, y, gx, gy);
    longint unsigned dx, dy;
    dx = (x > gx) ? x - gx : gx - x;
    dy = (y > gy) ? y - gy : gy - y;
    return int_root((dx * dx + dy * dy) << (2 * H_FRAC));
  endfunction

  task automatic astar_search(input int sx, sy, gx, gy, output logic [STAT_W-1:0] st);
    int gw, gh, it, goal, cur, best, nx, ny, nb, c, px, py, t;
    longint unsigned bf, bh, f;
    gw = clamp_dim(width_reg);
    gh = clamp_dim(height_reg);
    if (gx >= gw || gy >= gh || kind_store[gy*32+gx] == KIND_WALL ||
        kind_store[gy*32+gx] == KIND_LOCK) begin
      route_len = 0;
      last_iter = 0;
      st = ST_BLOCKED;
      return;
    end
    goal = gy * 32 + gx;
    for (int i = 0; i < CELLS; i++) begin
      g_cost[i] = 0; h_dist[i] = 0; back_dir[i] = PAR_NONE;
      is_closed[i] = 0; is_open[i] = 0;
    end
    open_n = 0;
    if (sx < gw && sy < gh) begin
      open_q[0] = sy * 32 + sx;
      is_open[sy*32+sx] = 1;
      open_n = 1;
    end
    it = 0;
    forever begin
      if (it > iter_reg) begin st = ST_LIMIT; break; end
      if (open_n == 0) begin st = ST_EMPTY; break; end
      best = 0;
      bf = (longint'(g_cost[open_q[0]]) << H_FRAC) + h_dist[open_q[0]];
      bh = h_dist[open_q[0]];
      for (int i = 1; i < open_n; i++) begin
        f = (longint'(g_cost[open_q[i]]) << H_FRAC) + h_dist[open_q[i]];
        if (f < bf || (f == bf && h_dist[open_q[i]] < bh)) begin
          best = i; bf = f; bh = h_dist[open_q[i]];
        end
      end
      cur = open_q[best];
      for (int i = best; i + 1 < open_n; i++) open_q[i] = open_q[i+1];
      open_n--;
      is_open[cur] = 0;
      is_closed[cur] = 1;
      if (cur == goal) begin st = ST_GOAL; break; end
      for (int k = 0; k < 4; k++) begin
        nx = cur % 32 + step_dx[k];
        ny = cur / 32 + step_dy[k];
        if (nx < 0 || ny < 0 || nx >= gw || ny >= gh) continue;
        nb = ny * 32 + nx;
        if (kind_store[nb] == KIND_WALL || is_closed[nb]) continue;
        if (g_cost[cur] + 1 < g_cost[nb] || !is_open[nb]) begin
          g_cost[nb] = (g_cost[cur] + 1) & 11'h7FF;
          h_dist[nb] = euclid_h(nx, ny, gx, gy);
          back_dir[nb] = 4 - k;
          if (!is_open[nb] && open_n < CELLS) begin
            open_q[open_n++] = nb;
            is_open[nb] = 1;
          end
        end
      end
      it++;
    end
    last_iter = it;
    // walk parent links back from the goal, then reverse
    route_len = 0;
    cur = goal;
    while (route_len < CELLS) begin
      route[route_len++] = cur;
      c = back_dir[cur];
      if (c < 1 || c > 4) break;
      px = cur % 32 + step_dx[c-1];
      py = cur / 32 + step_dy[c-1];
      if (px < 0 || py < 0 || px >= 32 || py >= 32) break;
      cur = py * 32 + px;
    end
    for (int i = 0; i < route_len / 2; i++) begin
      t = route[i];
      route[i] = route[route_len-1-i];
      route[route_len-1-i] = t;
    end
  endtask

  task automatic predict_item(input logic [1:0] fn, input int cx, cy, kd, gx, gy, pidx);
    search_result_t r;
    logic [STAT_W-1:0] st;
    // the ports carry only the low bits of each field
    cx = cx & 31; cy = cy & 31; kd = kd & 3;
    gx = gx & 31; gy = gy & 31; pidx = pidx & 10'h3FF;
    r = '0;
    r.status = ST_WRITE;
    if (fn == FN_WRITE) begin
      kind_store[cy*32+cx] = (kd == KIND_BAD) ? KIND_OPEN : KIND_W'(kd);
    end else if (fn == FN_SEARCH) begin
      astar_search(cx, cy, gx, gy, st);
      r.status = st;
      searches_run++;
    end else if (fn == FN_READ) begin
      if (pidx < route_len) begin
        r.status = ST_ENTRY;
        r.entry_x = COORD_W'(route[pidx] % 32);
        r.entry_y = COORD_W'(route[pidx] / 32);
      end else begin
        r.status = ST_BEYOND;
      end
    end
    r.path_length = CNT_W'(route_len);
    r.expansions = CNT_W'(last_iter);
    pending_results.insert(pending_results.size(), r);
  endtask

  // one item: random hold-off (none when no_gaps is set), then hold start until busy is seen low at an edge
  task automatic send_item(input logic [1:0] fn, input int cx, cy, kd, gx, gy, pidx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_func <= fn;
    in_cell_x <= COORD_W'(cx); in_cell_y <= COORD_W'(cy); in_cell_kind <= KIND_W'(kd);
    in_goal_x <= COORD_W'(gx); in_goal_y <= COORD_W'(gy); in_path_index <= PIDX_W'(pidx);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_item(fn, cx, cy, kd, gx, gy, pidx);
    items_sent++;
    @(negedge clk) start <= 1'b0;
  endtask

  // register writes only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = val & 10'h3F;
    else if (idx == CFG_HEIGHT) height_reg = val & 10'h3F;
    else if (idx == CFG_ITER) iter_reg = val;
  endtask

  always @(posedge clk) begin
    search_result_t w, got;
    if (rst_n && out_valid) begin
      got = '{out_status, out_path_length, out_expansions, out_entry_x, out_entry_y};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        w = pending_results.pop_front();
        if (got != w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", w, got);
        end
      end
    end
  end

  task automatic test_empty_store;
    send_item(FN_READ, 0, 0, 0, 0, 0, 0);          // no path yet
    send_item(2'd3, 31, 31, 3, 31, 31, 10'h3FF);   // unknown func
  endtask

  task automatic test_directed;
    send_item(FN_SEARCH, 0, 0, 0, 31, 31, 0);      // corner to corner, open grid
    send_item(FN_READ, 0, 0, 0, 0, 0, 0);
    send_item(FN_READ, 0, 0, 0, 0, 0, route_len - 1);
    send_item(FN_READ, 0, 0, 0, 0, 0, route_len);
    send_item(FN_READ, 0, 0, 0, 0, 0, 10'h3FF);
    send_item(FN_SEARCH, 7, 7, 0, 7, 7, 0);        // start is the goal
    send_item(FN_WRITE, 5, 5, KIND_LOCK, 0, 0, 0);
    send_item(FN_SEARCH, 0, 5, 0, 5, 5, 0);        // lock as goal
    send_item(FN_SEARCH, 5, 4, 0, 5, 6, 0);        // lock passable on the way
    send_item(FN_WRITE, 5, 5, KIND_BAD, 0, 0, 0);  // unknown kind reads as open
    send_item(FN_SEARCH, 5, 4, 0, 5, 5, 0);
    send_item(FN_WRITE, 0, 1, KIND_WALL, 0, 0, 0);
    send_item(FN_WRITE, 1, 0, KIND_WALL, 0, 0, 0);
    send_item(FN_SEARCH, 0, 0, 0, 3, 3, 0);        // walled-in start: open list runs dry
    send_item(FN_SEARCH, 3, 3, 0, 0, 1, 0);        // wall as goal
    send_item(FN_SEARCH, 3, 3, 0, 0, 0, 0);        // unreachable goal
    write_reg(CFG_WIDTH, 10'h3C4);                 // masked to 4 columns
    write_reg(CFG_ITER, 10'd0);
    send_item(FN_SEARCH, 0, 3, 0, 3, 3, 0);        // stops on the iteration limit
    send_item(FN_SEARCH, 3, 3, 0, 9, 0, 0);        // goal outside the grid
    send_item(FN_SEARCH, 9, 0, 0, 2, 2, 0);        // start outside the grid
    send_item(FN_READ, 0, 0, 0, 0, 0, 0);
    send_item(FN_WRITE, 31, 31, KIND_WALL, 0, 0, 0);  // outside grid, inside store
    send_item(FN_WRITE, 31, 31, KIND_OPEN, 0, 0, 0);
    send_item(FN_WRITE, 0, 1, KIND_OPEN, 0, 0, 0);
    send_item(FN_WRITE, 1, 0, KIND_OPEN, 0, 0, 0);
  endtask

  // one phase: new grid settings, then per search random cell writes, the search and path reads, plus some noise
  task automatic random_phase(input int w, h, it, searches, input int wall_pct);
    int gw, gh, cx, cy, kd, n;
    write_reg(CFG_WIDTH, CFG_DAT_W'(w));
    write_reg(CFG_HEIGHT, CFG_DAT_W'(h));
    write_reg(CFG_ITER, CFG_DAT_W'(it));
    gw = clamp_dim(w & 63);
    gh = clamp_dim(h & 63);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int s = 0; s < searches; s++) begin
      n = $urandom_range(2, 6);
      for (int i = 0; i < n; i++) begin
        cx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, gw - 1);
        cy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, gh - 1);
        kd = $urandom_range(0, 99);
        kd = (kd < wall_pct) ? KIND_WALL : (kd < wall_pct + 8) ? KIND_LOCK :
             (kd < wall_pct + 14) ? KIND_BAD : KIND_OPEN;
        send_item(FN_WRITE, cx, cy, kd, $urandom, $urandom, $urandom);
      end
      if ($urandom_range(0, 9) == 0)
        send_item(FN_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom,
                  $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
      else
        send_item(FN_SEARCH, $urandom_range(0, gw - 1), $urandom_range(0, gh - 1), $urandom,
                  $urandom_range(0, gw - 1), $urandom_range(0, gh - 1), $urandom);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_item(FN_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, route_len + 1));
      if ($urandom_range(0, 4) == 0)
        send_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_random;
    random_phase(8, 8, 100, 2, 25);
    random_phase(10'h3C5, 7, 1023, 2, 20);   // upper data bits ignored
    random_phase(0, 32, 50, 1, 10);          // zero width acts as one column
    random_phase(63, 1, 1023, 1, 10);        // over-wide clamps, single row
    random_phase(12, 10, 0, 2, 20);
    random_phase(6, 6, 10'h2AA, 2, 30);
    random_phase(32, 32, 1023, 2, 25);       // full grid, full budget
    random_phase(9, 16, 7, 2, 15);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_directed();
    test_random();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d searches over 8 grid settings",
             items_sent, results_seen, searches_run);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) kind_store[i] = KIND_OPEN;
    route_len = 0;
    last_iter = 0;
    #500ms;
    $display("simulation failed");
    $finish;
  end

endmodule
